@@ sv/cidt_pkg.sv @@
// shared types, codes and reset values of the can rx id tracking table
package cidt_pkg;

  localparam int DEF_ENTRIES = 16;

  localparam int ID_W    = 29;
  localparam int KEY_W   = 31;
  localparam int DLC_W   = 4;
  localparam int DATA_W  = 64;
  localparam int CYC_W   = 16;
  localparam int TIME_W  = 32;
  localparam int ORDER_W = 32;
  localparam int STAT_W  = 3;
  localparam int MASK_W  = 5;
  localparam int SLOT_W  = 4;
  localparam int MULT_W  = 4;
  localparam int CFG_IDX_W = 2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_IGNORED = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STAT_W-1:0] ST_CREATE  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOCHG   = 3'd3;
  localparam logic [STAT_W-1:0] ST_EDIT    = 3'd4;
  localparam logic [STAT_W-1:0] ST_DELETE  = 3'd5;

  // change mask bits
  localparam logic [MASK_W-1:0] CM_TIMEOUT = 5'h01;
  localparam logic [MASK_W-1:0] CM_DLC     = 5'h04;
  localparam logic [MASK_W-1:0] CM_DATA    = 5'h08;
  localparam logic [MASK_W-1:0] CM_CYCLE   = 5'h10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_TO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MULT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TO     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TO     = 2'd3;

  localparam logic [TIME_W-1:0] RST_DEFAULT_TO = 32'd3000;
  localparam logic [MULT_W-1:0] RST_MULT       = 4'd5;
  localparam logic [TIME_W-1:0] RST_MIN_TO     = 32'd1000;
  localparam logic [TIME_W-1:0] RST_MAX_TO     = 32'd30000;

  localparam logic [DLC_W-1:0] MAX_DLC = 4'd8;
  localparam logic [CYC_W-1:0] CYC_SAT = 16'hFFFF;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [DLC_W-1:0]   dlc;
    logic [DATA_W-1:0]  data;
    logic [CYC_W-1:0]   cycle;
    logic [TIME_W-1:0]  last;
    logic [TIME_W-1:0]  prev;
    logic [ORDER_W-1:0] order;
  } rec_t;

  typedef struct packed {
    logic [TIME_W-1:0] default_to;
    logic [MULT_W-1:0] mult;
    logic [TIME_W-1:0] min_to;
    logic [TIME_W-1:0] max_to;
  } cfg_t;

endpackage

@@ sv/cidt_store.sv @@
// entry memory: one write port, one registered read port
module cidt_store import cidt_pkg::*; #(
  parameter int DEPTH = DEF_ENTRIES,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  rec_t          wdata,
  input  logic [AW-1:0] raddr,
  output rec_t          rdata
);

  rec_t mem_r [DEPTH];
  rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/cidt_expiry.sv @@
// timeout of one entry and its expiry test
module cidt_expiry import cidt_pkg::*; (
  input  cfg_t              cfg,
  input  logic [CYC_W-1:0]  cycle,
  input  logic [TIME_W-1:0] last,
  input  logic [TIME_W-1:0] now,
  output logic              expired
);

  logic [CYC_W+MULT_W-1:0] prod;
  logic [TIME_W-1:0]       t_lo;
  logic [TIME_W-1:0]       t_clamp;
  logic [TIME_W-1:0]       timeout;
  logic [TIME_W-1:0]       age;

  always_comb begin
    prod = cycle * cfg.mult;
    t_lo = (TIME_W'(prod) < cfg.min_to) ? cfg.min_to : TIME_W'(prod);
    // upper clamp wins when the clamps cross
    t_clamp = (t_lo > cfg.max_to) ? cfg.max_to : t_lo;
    timeout = (cycle == '0) ? cfg.default_to : t_clamp;
    age = now - last;
    expired = (age >= timeout);
  end

endmodule

@@ sv/can_rx_id_tracking_table.sv @@
// top level: item sequencer around the entry memory
// An item is answered after a scan of the entry memory, read one slot per cycle
// through its single registered read port. The scan stops at the first matching
// or expired slot and the found entry is then written back; a miss writes a new
// entry to the first free slot, if any. A miss, a full table or a tick with nothing
// expired scans every slot. A frame with a length above eight skips the scan and
// goes straight to the result. One item is in work at a time and the input is
// free again in the cycle after the result is loaded; a finished result sits in
// the output register while the next item is taken. Valid bits live in flip-flops,
// so no clearing pass follows reset. Configuration writes are always taken.
module can_rx_id_tracking_table import cidt_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_ENTRIES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_action,
  input  logic [ID_W-1:0]      in_can_id,
  input  logic                 in_extended,
  input  logic                 in_remote,
  input  logic [DLC_W-1:0]     in_dlc,
  input  logic [DATA_W-1:0]    in_payload,
  input  logic [TIME_W-1:0]    in_now_ms,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STAT_W-1:0]    out_status,
  output logic [MASK_W-1:0]    out_change_mask,
  output logic [SLOT_W-1:0]    out_slot,
  output logic [ID_W-1:0]      out_entry_id,
  output logic [1:0]           out_entry_flags,
  output logic [DLC_W-1:0]     out_entry_dlc,
  output logic [DATA_W-1:0]    out_entry_data,
  output logic [CYC_W-1:0]     out_cycle_time_ms,
  output logic [ORDER_W-1:0]   out_order_stamp,
  output logic [TIME_W-1:0]    out_last_seen_ms,
  output logic [TIME_W-1:0]    out_previous_seen_ms,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_wdata
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;

  cfg_t cfg_r;

  logic               act_r;
  logic [KEY_W-1:0]   key_r;
  logic [DLC_W-1:0]   dlc_r;
  logic [DATA_W-1:0]  data_r;
  logic [TIME_W-1:0]  now_r;

  logic [CNT_W-1:0]   cnt_r;
  logic               ev_valid_r;
  logic [IDX_W-1:0]   ev_idx_r;
  logic               free_found_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic [IDX_W-1:0]   sel_idx_r;
  rec_t               rec_r;
  logic [TABLE_ENTRIES-1:0] vld_r;
  logic [ORDER_W-1:0] order_r;

  logic [STAT_W-1:0]  res_status_r;
  logic [MASK_W-1:0]  res_mask_r;
  logic [IDX_W-1:0]   res_slot_r;
  rec_t               res_rec_r;

  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [MASK_W-1:0]  out_mask_r;
  logic [SLOT_W-1:0]  out_slot_r;
  rec_t               out_rec_r;

  rec_t               rd_rec;
  logic               expired;
  logic               in_acc;
  logic [DATA_W-1:0]  in_data_masked;
  logic               ev_vld;
  logic               found;
  logic               scan_end;
  logic [TIME_W-1:0]  elapsed;
  logic [CYC_W-1:0]   cyc_sat;
  logic [MASK_W-1:0]  edit_mask;
  rec_t               upd_rec;
  rec_t               new_rec;
  rec_t               clr_rec;
  rec_t               del_rec;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  rec_t               mem_wdata;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  cidt_store #(.DEPTH(TABLE_ENTRIES), .AW(IDX_W)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (rd_rec)
  );

  cidt_expiry u_expiry (
    .cfg     (cfg_r),
    .cycle   (rd_rec.cycle),
    .last    (rd_rec.last),
    .now     (now_r),
    .expired (expired)
  );

  // bytes at and past the length read as zero
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      in_data_masked[8*b +: 8] = (4'(b) < in_dlc) ? in_payload[8*b +: 8] : 8'h00;
    end
  end

  always_comb begin
    ev_vld   = vld_r[ev_idx_r];
    found    = ev_valid_r && ev_vld &&
               (act_r ? expired : (rd_rec.key == key_r));
    scan_end = ev_valid_r && !found && (ev_idx_r == LAST_IDX);
  end

  always_comb begin
    elapsed = now_r - rec_r.last;
    cyc_sat = (elapsed[TIME_W-1:CYC_W] != '0) ? CYC_SAT : elapsed[CYC_W-1:0];
    edit_mask = '0;
    if (rec_r.dlc != dlc_r)    edit_mask = edit_mask | CM_DLC;
    if (rec_r.data != data_r)  edit_mask = edit_mask | CM_DATA;
    if (rec_r.cycle != cyc_sat) edit_mask = edit_mask | CM_CYCLE;

    upd_rec       = rec_r;
    upd_rec.dlc   = dlc_r;
    upd_rec.data  = data_r;
    upd_rec.cycle = cyc_sat;
    upd_rec.prev  = rec_r.last;
    upd_rec.last  = now_r;
    upd_rec.order = (edit_mask != '0) ? order_r : rec_r.order;

    new_rec       = '0;
    new_rec.key   = key_r;
    new_rec.dlc   = dlc_r;
    new_rec.data  = data_r;
    new_rec.last  = now_r;
    new_rec.order = order_r;

    clr_rec       = '0;
    clr_rec.order = order_r;

    // deleted entry as it was, with its new stamp
    del_rec       = rec_r;
    del_rec.order = order_r;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sel_idx_r;
    mem_wdata = upd_rec;
    if (state_r == S_FIN && !act_r && free_found_r) begin
      mem_we    = 1'b1;
      mem_waddr = free_idx_r;
      mem_wdata = new_rec;
    end else if (state_r == S_UPD) begin
      mem_we    = 1'b1;
      mem_wdata = act_r ? clr_rec : upd_rec;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = (!in_action && in_dlc > MAX_DLC) ? S_OUT : S_SCAN;
      S_SCAN: begin
        if (found)         state_nxt = S_UPD;
        else if (scan_end) state_nxt = S_FIN;
      end
      S_FIN:  state_nxt = S_OUT;
      S_UPD:  state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= '{default_to: RST_DEFAULT_TO, mult: RST_MULT,
                       min_to: RST_MIN_TO, max_to: RST_MAX_TO};
      vld_r       <= '0;
      order_r     <= ORDER_W'(1);
      out_valid_r <= 1'b0;
      ev_valid_r  <= 1'b0;
      free_found_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DEFAULT_TO: cfg_r.default_to <= cfg_wdata;
          REG_MULT:       cfg_r.mult       <= cfg_wdata[MULT_W-1:0];
          REG_MIN_TO:     cfg_r.min_to     <= cfg_wdata;
          REG_MAX_TO:     cfg_r.max_to     <= cfg_wdata;
          default: ;
        endcase
      end

      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          cnt_r        <= '0;
          ev_valid_r   <= 1'b0;
          free_found_r <= 1'b0;
        end
        S_SCAN: begin
          if (found) begin
            ev_valid_r <= 1'b0;
          end else if (cnt_r < CNT_END) begin
            ev_idx_r   <= cnt_r[IDX_W-1:0];
            ev_valid_r <= 1'b1;
            cnt_r      <= cnt_r + CNT_W'(1);
          end else begin
            ev_valid_r <= 1'b0;
          end
          if (ev_valid_r && !ev_vld && !free_found_r) begin
            free_found_r <= 1'b1;
            free_idx_r   <= ev_idx_r;
          end
        end
        S_FIN: begin
          if (!act_r && free_found_r) begin
            vld_r[free_idx_r] <= 1'b1;
            order_r <= order_r + ORDER_W'(1);
          end
        end
        S_UPD: begin
          if (act_r) begin
            vld_r[sel_idx_r] <= 1'b0;
            order_r <= order_r + ORDER_W'(1);
          end else if (edit_mask != '0) begin
            order_r <= order_r + ORDER_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // item capture, scan results and result assembly
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r  <= in_action;
      key_r  <= {in_remote, in_extended, in_can_id};
      dlc_r  <= in_dlc;
      data_r <= in_data_masked;
      now_r  <= in_now_ms;
      // ignored frame
      res_status_r <= ST_IGNORED;
      res_mask_r   <= '0;
      res_slot_r   <= '0;
      res_rec_r    <= '0;
    end
    if (state_r == S_SCAN && found) begin
      rec_r     <= rd_rec;
      sel_idx_r <= ev_idx_r;
    end
    if (state_r == S_FIN) begin
      res_mask_r <= '0;
      if (act_r) begin
        res_status_r <= ST_NOCHG;
        res_slot_r   <= '0;
        res_rec_r    <= '0;
      end else if (free_found_r) begin
        res_status_r <= ST_CREATE;
        res_slot_r   <= free_idx_r;
        res_rec_r    <= new_rec;
      end else begin
        res_status_r <= ST_FULL;
        res_slot_r   <= '0;
        res_rec_r    <= '0;
      end
    end
    if (state_r == S_UPD) begin
      res_slot_r <= sel_idx_r;
      if (act_r) begin
        res_status_r <= ST_DELETE;
        res_mask_r   <= CM_TIMEOUT;
        res_rec_r    <= del_rec;
      end else begin
        res_status_r <= (edit_mask != '0) ? ST_EDIT : ST_NOCHG;
        res_mask_r   <= edit_mask;
        res_rec_r    <= upd_rec;
      end
    end
    if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
      out_status_r <= res_status_r;
      out_mask_r   <= res_mask_r;
      out_slot_r   <= SLOT_W'(res_slot_r);
      out_rec_r    <= res_rec_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_change_mask      = out_mask_r;
  assign out_slot             = out_slot_r;
  assign out_entry_id         = out_rec_r.key[ID_W-1:0];
  assign out_entry_flags      = out_rec_r.key[KEY_W-1:ID_W];
  assign out_entry_dlc        = out_rec_r.dlc;
  assign out_entry_data       = out_rec_r.data;
  assign out_cycle_time_ms    = out_rec_r.cycle;
  assign out_order_stamp      = out_rec_r.order;
  assign out_last_seen_ms     = out_rec_r.last;
  assign out_previous_seen_ms = out_rec_r.prev;

endmodule

@@ sv/cidt_checker.sv @@
// port level checks of the tracking table, bound to the top level
module cidt_checker import cidt_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [STAT_W-1:0] out_status,
  input logic [MASK_W-1:0] out_change_mask,
  input logic [SLOT_W-1:0] out_slot,
  input logic [ID_W-1:0]   out_entry_id
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_slot))
    else $error("stalled result changed");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_DELETE)
    else $error("status code out of range");

  // ignored and full carry no entry
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_IGNORED || out_status == ST_FULL)
      |-> out_slot == '0 && out_entry_id == '0 && out_change_mask == '0)
    else $error("empty result carries entry fields");

  a_delete_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DELETE |-> out_change_mask == CM_TIMEOUT)
    else $error("delete without timeout mask");

endmodule

bind can_rx_id_tracking_table cidt_checker u_cidt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_change_mask (out_change_mask),
  .out_slot        (out_slot),
  .out_entry_id    (out_entry_id)
);
